FILE: hdl/som_best_matching_unit_core_assert.svh
// Assertion helpers for the best matching unit core.
`ifndef SOM_BEST_MATCHING_UNIT_CORE_ASSERT_SVH
`define SOM_BEST_MATCHING_UNIT_CORE_ASSERT_SVH

`ifndef SYNTH

`define SOM_BMU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define SOM_BMU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `SOM_BMU_ASSERT(label, clk, rst_n, !(cond), msg)

`else

`define SOM_BMU_ASSERT(label, clk, rst_n, prop, msg)

`define SOM_BMU_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

FILE: hdl/som_bmu_pkg.sv
`timescale 1ns / 1ps

package som_bmu_pkg;

  localparam int MaxNodes = 64;
  localparam int MaxDims  = 4;
  localparam int CompBits = 16;

  localparam int NodeBits     = $clog2(MaxNodes);
  localparam int DistBits     = 36;
  localparam int NodesCfgBits = 7;
  localparam int DimsCfgBits  = 3;
  localparam int CfgDataBits  = DistBits;
  localparam int CfgIdxBits   = 2;

  localparam int WordBits = MaxDims * CompBits;
  localparam int SqBits   = 2 * CompBits;
  localparam int SumBits  = SqBits + $clog2(MaxDims) + 1;

  localparam logic [CfgIdxBits-1:0] CfgNodesInUse   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgDimsInUse    = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgDistanceLimit = 2'd2;

  localparam logic [NodesCfgBits-1:0] NodesReset = 7'd49;
  localparam logic [DimsCfgBits-1:0]  DimsReset  = 3'd3;
  localparam logic [DistBits-1:0]     LimitReset = 36'd65536000000;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

endpackage

FILE: hdl/som_best_matching_unit_core.sv
`timescale 1ns / 1ps

// Best matching unit of a self-organizing map. A load beat (kind 0) writes one node's
// weights and gives no result; busy stays low. A query beat (kind 1) reads nodes
// 0 .. N-1 from the weight memory, one node per cycle on its single read port, through
// a four-stage read/square/sum/compare pipeline, where N is nodes_in_use taken as 1
// when zero and as 64 when larger. The result is on the outputs for one cycle with
// valid_o; busy is high until that cycle, so a new beat may be taken at its end.
// The receiver cannot stall: capture the result in the cycle valid_o is high.

`include "som_best_matching_unit_core_assert.svh"

module som_best_matching_unit_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   kind_i,
  input  logic [som_bmu_pkg::NodeBits-1:0]       node_index_i,
  input  logic signed [som_bmu_pkg::CompBits-1:0] comp0_i,
  input  logic signed [som_bmu_pkg::CompBits-1:0] comp1_i,
  input  logic signed [som_bmu_pkg::CompBits-1:0] comp2_i,
  input  logic signed [som_bmu_pkg::CompBits-1:0] comp3_i,
  input  logic                                   cfg_we_i,
  input  logic [som_bmu_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [som_bmu_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  output logic                                   valid_o,
  output logic [som_bmu_pkg::NodeBits-1:0]       winner_o,
  output logic [som_bmu_pkg::DistBits-1:0]       best_distance_o,
  output logic                                   no_match_o
);

  localparam int NB = som_bmu_pkg::NodeBits;
  localparam int CB = som_bmu_pkg::CompBits;
  localparam int ND = som_bmu_pkg::MaxDims;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0] state_q, state_d;

  logic [som_bmu_pkg::NodesCfgBits-1:0] nodes_q;
  logic [som_bmu_pkg::DimsCfgBits-1:0]  dims_q;
  logic [som_bmu_pkg::DistBits-1:0]     limit_q;

  logic [NB-1:0] last_idx;
  logic [som_bmu_pkg::DimsCfgBits-1:0] dims_eff;

  logic accept, load_beat, query_beat;
  logic ram_we, ram_re;
  logic [som_bmu_pkg::WordBits-1:0] ram_wdata, ram_rdata;

  logic [NB-1:0] rd_idx_q;
  logic          rd_last;

  logic [CB-1:0] x_q [ND];

  logic          v1_q, v2_q, v3_q;
  logic          last1_q, last2_q, last3_q;
  logic [NB-1:0] idx1_q, idx2_q, idx3_q;

  logic [som_bmu_pkg::SqBits-1:0]  sq_d [ND];
  logic [som_bmu_pkg::SqBits-1:0]  sq2_q [ND];
  logic [som_bmu_pkg::SumBits-1:0] sum_d, sum3_q;

  logic [som_bmu_pkg::DistBits-1:0] best_q, best_d;
  logic [NB-1:0]                    win_q, win_d;
  logic                             found_q, found_d;

  logic                             valid_q;
  logic [NB-1:0]                    winner_q;
  logic [som_bmu_pkg::DistBits-1:0] dist_q;
  logic                             no_match_q;

  assign busy       = (state_q != StIdle);
  assign accept     = start && !busy;
  assign load_beat  = accept && (kind_i == som_bmu_pkg::KindLoad);
  assign query_beat = accept && (kind_i == som_bmu_pkg::KindQuery);

  always_comb begin
    if (nodes_q == '0) begin
      last_idx = '0;
    end else if (nodes_q > som_bmu_pkg::NodesCfgBits'(som_bmu_pkg::MaxNodes)) begin
      last_idx = NB'(som_bmu_pkg::MaxNodes - 1);
    end else begin
      last_idx = NB'(nodes_q - som_bmu_pkg::NodesCfgBits'(1));
    end
    if (dims_q == '0) begin
      dims_eff = som_bmu_pkg::DimsCfgBits'(1);
    end else if (dims_q > som_bmu_pkg::DimsCfgBits'(ND)) begin
      dims_eff = som_bmu_pkg::DimsCfgBits'(ND);
    end else begin
      dims_eff = dims_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= som_bmu_pkg::NodesReset;
      dims_q  <= som_bmu_pkg::DimsReset;
      limit_q <= som_bmu_pkg::LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        som_bmu_pkg::CfgNodesInUse: begin
          nodes_q <= cfg_wdata_i[som_bmu_pkg::NodesCfgBits-1:0];
        end
        som_bmu_pkg::CfgDimsInUse: begin
          dims_q <= cfg_wdata_i[som_bmu_pkg::DimsCfgBits-1:0];
        end
        som_bmu_pkg::CfgDistanceLimit: begin
          limit_q <= cfg_wdata_i[som_bmu_pkg::DistBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_we    = load_beat;
  assign ram_wdata = {comp3_i, comp2_i, comp1_i, comp0_i};
  assign ram_re    = (state_q == StIssue);
  assign rd_last   = (rd_idx_q == last_idx);

  som_bmu_ram #(
    .Width(som_bmu_pkg::WordBits),
    .Depth(som_bmu_pkg::MaxNodes)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(node_index_i),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (query_beat) begin
          state_d = StIssue;
        end
      end
      StIssue: begin
        if (rd_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (v3_q && last3_q) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_idx_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (query_beat) begin
        rd_idx_q <= '0;
      end else if (ram_re) begin
        rd_idx_q <= rd_idx_q + NB'(1);
      end
      v1_q    <= ram_re;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_q <= v3_q && last3_q;
    end
  end

  always_comb begin
    logic signed [CB:0] diff;
    logic        [CB:0] neg;
    logic        [CB-1:0] mag;
    logic signed [CB-1:0] w;
    diff = '0;
    neg  = '0;
    mag  = '0;
    w    = '0;
    for (int d = 0; d < ND; d++) begin
      w    = ram_rdata[d*CB +: CB];
      diff = $signed({x_q[d][CB-1], x_q[d]}) - $signed({w[CB-1], w});
      neg  = -diff;
      mag  = diff[CB] ? neg[CB-1:0] : diff[CB-1:0];
      if (som_bmu_pkg::DimsCfgBits'(d) < dims_eff) begin
        sq_d[d] = som_bmu_pkg::SqBits'(mag) * som_bmu_pkg::SqBits'(mag);
      end else begin
        sq_d[d] = '0;
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int d = 0; d < ND; d++) begin
      sum_d = sum_d + som_bmu_pkg::SumBits'(sq2_q[d]);
    end
  end

  always_comb begin
    best_d  = best_q;
    win_d   = win_q;
    found_d = found_q;
    if (v3_q && (som_bmu_pkg::DistBits'(sum3_q) < best_q)) begin
      best_d  = som_bmu_pkg::DistBits'(sum3_q);
      win_d   = idx3_q;
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_beat) begin
      x_q[0]  <= comp0_i;
      x_q[1]  <= comp1_i;
      x_q[2]  <= comp2_i;
      x_q[3]  <= comp3_i;
      best_q  <= limit_q;
      win_q   <= '0;
      found_q <= 1'b0;
    end else begin
      best_q  <= best_d;
      win_q   <= win_d;
      found_q <= found_d;
    end
    last1_q <= rd_last;
    idx1_q  <= rd_idx_q;
    last2_q <= last1_q;
    idx2_q  <= idx1_q;
    sq2_q   <= sq_d;
    last3_q <= last2_q;
    idx3_q  <= idx2_q;
    sum3_q  <= sum_d;
    if (v3_q && last3_q) begin
      winner_q   <= win_d;
      dist_q     <= best_d;
      no_match_q <= !found_d;
    end
  end

  assign valid_o         = valid_q;
  assign winner_o        = winner_q;
  assign best_distance_o = dist_q;
  assign no_match_o      = no_match_q;

  `SOM_BMU_ASSERT(a_result_when_idle, clk_i, rst_ni, valid_o |-> !busy, "result while busy")
  `SOM_BMU_ASSERT_NEVER(a_no_write_in_scan, clk_i, rst_ni, ram_we && ram_re, "load during scan")
  `SOM_BMU_ASSERT(a_last_gives_result, clk_i, rst_ni, (v3_q && last3_q) |=> valid_o, "lost result")
  `SOM_BMU_ASSERT(a_single_strobe, clk_i, rst_ni, valid_o |=> !valid_o, "repeated result")
  `SOM_BMU_ASSERT(a_busy_from_query, clk_i, rst_ni, $rose(busy) |-> $past(start && (kind_i == som_bmu_pkg::KindQuery)), "busy without query")

endmodule

FILE: hdl/som_bmu_ram.sv
`timescale 1ns / 1ps

module som_bmu_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/som_bmu_checker.sv
`timescale 1ns / 1ps

module som_bmu_checker
  import som_bmu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    kind_i,
  input  logic [NodeBits-1:0]     node_index_i,
  input  logic [CompBits-1:0]     comp0_i,
  input  logic [CompBits-1:0]     comp1_i,
  input  logic [CompBits-1:0]     comp2_i,
  input  logic [CompBits-1:0]     comp3_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [CfgDataBits-1:0]  cfg_wdata_i,
  input  logic                    valid_o,
  input  logic [NodeBits-1:0]     winner_o,
  input  logic [DistBits-1:0]     best_distance_o,
  input  logic                    no_match_o,
  output int unsigned             fail_count_o,
  output int unsigned             queued_o
);

  typedef struct packed {
    logic [NodeBits-1:0] winner;
    logic [DistBits-1:0] best_distance;
    logic                no_match;
  } bmu_match_t;

  logic [WordBits-1:0]     node_weights [MaxNodes];
  logic [NodesCfgBits-1:0] nodes_cfg;
  logic [DimsCfgBits-1:0]  dims_cfg;
  logic [DistBits-1:0]     limit_cfg;
  bmu_match_t              expected_matches [$];
  bmu_match_t              oldest;
  logic [WordBits-1:0]     probe;
  int unsigned             fails;

  function automatic logic [DistBits-1:0] squared_distance(
    input logic [WordBits-1:0] vec_a,
    input logic [WordBits-1:0] vec_b,
    input int                  dims
  );
    logic signed [CompBits-1:0] a;
    logic signed [CompBits-1:0] b;
    logic signed [CompBits:0]   diff;
    logic [CompBits:0]          mag;
    logic [DistBits-1:0]        sq;
    logic [DistBits:0]          acc;
    acc = '0;
    for (int d = 0; d < dims; d++) begin
      a = vec_a[d*CompBits +: CompBits];
      b = vec_b[d*CompBits +: CompBits];
      diff = a - b;
      mag = diff[CompBits] ? -diff : diff;
      if (mag > 'h3FFFF) sq = '1;
      else sq = DistBits'(mag) * DistBits'(mag);
      acc = {1'b0, acc[DistBits-1:0]} + {1'b0, sq};
      if (acc[DistBits]) acc = {1'b0, {DistBits{1'b1}}};
    end
    return acc[DistBits-1:0];
  endfunction

  function automatic bmu_match_t find_best_match(input logic [WordBits-1:0] query_vec);
    int                  nodes;
    int                  dims;
    logic [DistBits-1:0] span;
    bmu_match_t          res;
    nodes = (nodes_cfg == 0) ? 1 : ((nodes_cfg > MaxNodes) ? MaxNodes : int'(nodes_cfg));
    dims = (dims_cfg == 0) ? 1 : ((dims_cfg > MaxDims) ? MaxDims : int'(dims_cfg));
    res.winner = '0;
    res.best_distance = limit_cfg;
    res.no_match = 1'b1;
    for (int n = 0; n < nodes; n++) begin
      span = squared_distance(query_vec, node_weights[n], dims);
      if (span < res.best_distance) begin
        res.best_distance = span;
        res.winner = NodeBits'(n);
        res.no_match = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_cfg = NodesReset;
      dims_cfg = DimsReset;
      limit_cfg = LimitReset;
      expected_matches.delete();
      fails = 0;
      fail_count_o <= 0;
      queued_o <= 0;
    end else begin
      if (valid_o) begin
        if (expected_matches.size() == 0) begin
          $display("%0t unexpected result: winner %0d distance %0d no_match %0b",
                   $time, winner_o, best_distance_o, no_match_o);
          fails++;
        end else begin
          oldest = expected_matches.pop_front();
          if (winner_o !== oldest.winner) begin
            $display("%0t winner mismatch: expected %0d actual %0d",
                     $time, oldest.winner, winner_o);
            fails++;
          end
          if (best_distance_o !== oldest.best_distance) begin
            $display("%0t best_distance mismatch: expected %0d actual %0d",
                     $time, oldest.best_distance, best_distance_o);
            fails++;
          end
          if (no_match_o !== oldest.no_match) begin
            $display("%0t no_match mismatch: expected %0b actual %0b",
                     $time, oldest.no_match, no_match_o);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgNodesInUse:    nodes_cfg = cfg_wdata_i[NodesCfgBits-1:0];
          CfgDimsInUse:     dims_cfg = cfg_wdata_i[DimsCfgBits-1:0];
          CfgDistanceLimit: limit_cfg = cfg_wdata_i[DistBits-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        probe = {comp3_i, comp2_i, comp1_i, comp0_i};
        if (kind_i == KindLoad) begin
          if (int'(node_index_i) < MaxNodes) node_weights[node_index_i] = probe;
        end else begin
          expected_matches.insert(expected_matches.size(), find_best_match(probe));
        end
      end
      fail_count_o <= fails;
      queued_o <= expected_matches.size();
    end
  end

endmodule

FILE: tb/tb_som_best_matching_unit_core.sv
`timescale 1ns / 1ps

module tb_som_best_matching_unit_core;
  import som_bmu_pkg::*;

  localparam int ItemTarget   = 1850;
  localparam int PhaseItems   = 150;
  localparam int SettleCycles = MaxNodes + 8;
  localparam int IdleLimit    = 2000;

  localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   kind_i = KindLoad;
  logic [NodeBits-1:0]    node_index_i = '0;
  logic [CompBits-1:0]    comp0_i = '0;
  logic [CompBits-1:0]    comp1_i = '0;
  logic [CompBits-1:0]    comp2_i = '0;
  logic [CompBits-1:0]    comp3_i = '0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic                   valid_o;
  logic [NodeBits-1:0]    winner_o;
  logic [DistBits-1:0]    best_distance_o;
  logic                   no_match_o;
  int unsigned            mismatch_count;
  int unsigned            queued_matches;

  logic                   node_loaded [MaxNodes];
  logic [WordBits-1:0]    node_words [MaxNodes];
  int                     nodes_eff = NodesReset;
  int                     items_sent = 0;
  int                     phase_sent;
  int                     burst_len;
  int                     quiet_cycles = 0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  som_best_matching_unit_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .node_index_i    (node_index_i),
    .comp0_i         (comp0_i),
    .comp1_i         (comp1_i),
    .comp2_i         (comp2_i),
    .comp3_i         (comp3_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .valid_o         (valid_o),
    .winner_o        (winner_o),
    .best_distance_o (best_distance_o),
    .no_match_o      (no_match_o)
  );

  som_bmu_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .node_index_i    (node_index_i),
    .comp0_i         (comp0_i),
    .comp1_i         (comp1_i),
    .comp2_i         (comp2_i),
    .comp3_i         (comp3_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .valid_o         (valid_o),
    .winner_o        (winner_o),
    .best_distance_o (best_distance_o),
    .no_match_o      (no_match_o),
    .fail_count_o    (mismatch_count),
    .queued_o        (queued_matches)
  );

  task automatic send_beat(
    input logic                kind,
    input logic [NodeBits-1:0] idx,
    input logic [WordBits-1:0] vec
  );
    start <= 1'b1;
    kind_i <= kind;
    node_index_i <= idx;
    {comp3_i, comp2_i, comp1_i, comp0_i} <= vec;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    phase_sent++;
    if (kind == KindLoad) begin
      node_loaded[idx] = 1'b1;
      node_words[idx] = vec;
    end
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic settle();
    pause(1);
    while (queued_matches != 0 || busy) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    int v;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgNodesInUse) begin
      v = int'(data[NodesCfgBits-1:0]);
      nodes_eff = (v == 0) ? 1 : ((v > MaxNodes) ? MaxNodes : v);
    end
  endtask

  function automatic logic [WordBits-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WordBits-1:0] small_word();
    logic [WordBits-1:0] w;
    for (int d = 0; d < MaxDims; d++)
      w[d*CompBits +: CompBits] = CompBits'($urandom_range(0, 1023)) - CompBits'(512);
    return w;
  endfunction

  function automatic logic [WordBits-1:0] nudge(input logic [WordBits-1:0] w);
    logic [WordBits-1:0] r;
    for (int d = 0; d < MaxDims; d++)
      r[d*CompBits +: CompBits] = w[d*CompBits +: CompBits]
                                  + CompBits'($urandom_range(0, 32)) - CompBits'(16);
    return r;
  endfunction

  function automatic logic [WordBits-1:0] load_vector();
    int k;
    k = $urandom_range(0, MaxNodes - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_word();
      4, 5, 6, 7: return small_word();
      default: return node_loaded[k] ? node_words[k] : small_word();
    endcase
  endfunction

  function automatic int first_missing();
    for (int n = 0; n < nodes_eff; n++)
      if (!node_loaded[n]) return n;
    return -1;
  endfunction

  task automatic random_beat();
    int                  miss;
    int                  pick;
    logic [WordBits-1:0] vec;
    miss = first_missing();
    if (miss >= 0) begin
      send_beat(KindLoad, NodeBits'(miss), load_vector());
    end else if ($urandom_range(0, 9) < 3) begin
      send_beat(KindLoad, NodeBits'($urandom_range(0, MaxNodes - 1)), load_vector());
    end else begin
      pick = $urandom_range(0, nodes_eff - 1);
      case ($urandom_range(0, 9))
        0, 1:       vec = node_words[pick];
        2, 3, 4, 5: vec = nudge(node_words[pick]);
        default:    vec = rand_word();
      endcase
      send_beat(KindQuery, NodeBits'($urandom), vec);
    end
  endtask

  task automatic random_settings();
    logic [CfgDataBits-1:0] data;
    data = CfgDataBits'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0:       data[NodesCfgBits-1:0] = '0;
      1:       data[NodesCfgBits-1:0] = NodesCfgBits'(MaxNodes);
      2:       data[NodesCfgBits-1:0] = NodesCfgBits'($urandom_range(MaxNodes + 1, 127));
      3:       data[NodesCfgBits-1:0] = NodesCfgBits'(1);
      default: data[NodesCfgBits-1:0] = NodesCfgBits'($urandom_range(2, 16));
    endcase
    if ($urandom_range(0, 1)) data[CfgDataBits-1:NodesCfgBits] = '0;
    cfg_write(CfgNodesInUse, data);
    data = CfgDataBits'({$urandom, $urandom});
    data[DimsCfgBits-1:0] = DimsCfgBits'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) data[CfgDataBits-1:DimsCfgBits] = '0;
    cfg_write(CfgDimsInUse, data);
    case ($urandom_range(0, 6))
      0:       data = '1;
      1:       data = '0;
      2:       data = LimitReset;
      3:       data = CfgDataBits'({$urandom, $urandom});
      4:       data = CfgDataBits'($urandom_range(0, 4096));
      5:       data = CfgDataBits'($urandom_range(0, 1 << 24));
      default: data = CfgDataBits'($urandom) << $urandom_range(0, 4);
    endcase
    cfg_write(CfgDistanceLimit, data);
    if ($urandom_range(0, 7) == 0) cfg_write(CfgUnused, CfgDataBits'({$urandom, $urandom}));
  endtask

  initial begin
    for (int n = 0; n < MaxNodes; n++) begin
      node_loaded[n] = 1'b0;
      node_words[n] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(CfgNodesInUse, CfgDataBits'(4));
    cfg_write(CfgDimsInUse, CfgDataBits'(4));
    cfg_write(CfgDistanceLimit, '1);
    send_beat(KindLoad, NodeBits'(0), {MaxDims{16'h8000}});
    send_beat(KindLoad, NodeBits'(1), {MaxDims{16'h7FFF}});
    send_beat(KindLoad, NodeBits'(2), '0);
    send_beat(KindLoad, NodeBits'(3), '0);
    send_beat(KindLoad, NodeBits'(MaxNodes - 1), {2{16'hAAAA, 16'h5555}});
    send_beat(KindQuery, '1, {MaxDims{16'h7FFF}});
    send_beat(KindQuery, '0, {MaxDims{16'h8000}});
    send_beat(KindQuery, '0, '0);
    send_beat(KindQuery, '1, {2{16'h5555, 16'hAAAA}});
    send_beat(KindQuery, '0, {MaxDims{16'h0001}});
    settle();
    cfg_write(CfgDistanceLimit, '0);
    send_beat(KindQuery, '0, '0);
    settle();
    cfg_write(CfgDistanceLimit, CfgDataBits'(1));
    send_beat(KindQuery, '0, '0);
    settle();
    cfg_write(CfgDimsInUse, '0);
    cfg_write(CfgDistanceLimit, '1);
    send_beat(KindQuery, '0, {{3{16'h8000}}, 16'h7FFF});
    settle();
    cfg_write(CfgDimsInUse, CfgDataBits'(7));
    send_beat(KindQuery, '0, {{3{16'h8000}}, 16'h7FFF});
    settle();
    cfg_write(CfgNodesInUse, '0);
    cfg_write(CfgUnused, '1);
    send_beat(KindQuery, '0, {MaxDims{16'h7FFF}});

    while (items_sent < ItemTarget) begin
      settle();
      random_settings();
      phase_sent = 0;
      while (phase_sent < PhaseItems && items_sent < ItemTarget) begin
        burst_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
        repeat (burst_len) random_beat();
        pause(($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6));
      end
    end

    settle();
    if (mismatch_count == 0 && queued_matches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || valid_o || !rst_ni) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
